// ===== rtl/core/spq_pkg.sv =====
// Shared types and constants of the sorted priority queue with push-out.
`default_nettype none
package spq_pkg;

	localparam int CNT_W     = 6;
	localparam int BYTES_W   = 24;
	localparam int HANDLE_W  = 16;
	localparam int PRIO_W    = 32;
	localparam int SIZE_W    = 16;
	localparam int KIND_W    = 3;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_W     = 24;
	localparam int S_DATA_W  = 64;
	localparam int M_DATA_W  = 96;

	localparam logic [CNT_W-1:0]   MAX_PACKETS_RST = 6'd32;
	localparam logic [BYTES_W-1:0] MAX_BYTES_RST   = 24'd225000;

	localparam logic CMD_ENQ = 1'b0;
	localparam logic CMD_DEQ = 1'b1;

	localparam logic [CFG_IDX_W-1:0] CFG_LIMIT_BY_PACKETS = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_PACKETS      = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_BYTES        = 2'd2;

	localparam logic [KIND_W-1:0] KIND_ACCEPTED  = 3'd0;
	localparam logic [KIND_W-1:0] KIND_DROPPED   = 3'd1;
	localparam logic [KIND_W-1:0] KIND_PUSHED    = 3'd2;
	localparam logic [KIND_W-1:0] KIND_DEQUEUED  = 3'd3;
	localparam logic [KIND_W-1:0] KIND_DEQ_EMPTY = 3'd4;

	typedef struct packed {
		logic [SIZE_W-1:0]   bytes;
		logic [PRIO_W-1:0]   prio;
		logic [HANDLE_W-1:0] handle;
	} entry_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHECK,
		ST_TAIL,
		ST_DROP,
		ST_SCAN,
		ST_PLACE,
		ST_DEQ,
		ST_EMPTY
	} state_t;

endpackage
`default_nettype wire

// ===== rtl/core/pushout_sorted_priority_queue.sv =====
// Top level of the sorted priority queue with push-out.
// The queue holds up to DEPTH packets (handle, priority, byte size) in one RAM used as a ring
// whose head is the packet served next; entries stay sorted by ascending priority, equal
// priorities in arrival order. An input beat on s_* is an enqueue (s_tuser = 0) or a dequeue
// (s_tuser = 1); each one yields result beats on m_*, the last carrying m_tlast. One input beat
// is worked on at a time; s_tready rises again once the final result sits in the output
// register, so the next beat overlaps that result waiting on m_tready. A dequeue reads the
// head as its beat is taken and loads it into the output register from the dequeue state.
// An enqueue reads the tail, then moves each stored packet with a larger priority one slot
// up (one write per cycle, reading the next one down ahead) until the scan reaches the head
// or stops on a packet that ranks ahead, then writes the arrival. Each push-out reads the
// tail, then decides; a drop after a failed tail compare goes through the drop state. The
// slowest item is a byte-mode flush of a full queue; the single RAM read port sets the pace.
// The limit registers are written through cfg_we/cfg_index/cfg_data; the user must write
// them only while the queue is idle, the block itself does not enforce it. The RAM needs no
// clearing: only the first packet_count entries are ever read.
`default_nettype none
module pushout_sorted_priority_queue #(
	parameter int DEPTH = 32
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	// input stream
	input  wire logic                                s_tvalid,
	output logic                                     s_tready,
	// tdata: pkt_handle[15:0], priority_req[47:16], pkt_bytes[63:48]
	input  wire logic [spq_pkg::S_DATA_W-1:0]        s_tdata,
	// tuser: cmd (0 enqueue, 1 dequeue)
	input  wire logic                                s_tuser,
	// result stream
	output logic                                     m_tvalid,
	input  wire logic                                m_tready,
	// tdata: out_handle[15:0], out_priority[47:16], out_bytes[63:48],
	//        queued_packets[69:64], queued_bytes[93:70], zero pad[95:94]
	output logic      [spq_pkg::M_DATA_W-1:0]        m_tdata,
	// tuser: kind[2:0]
	output logic      [spq_pkg::KIND_W-1:0]          m_tuser,
	output logic                                     m_tlast,
	// configuration writes
	input  wire logic                                cfg_we,
	input  wire logic [spq_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  wire logic [spq_pkg::CFG_W-1:0]           cfg_data
);

	localparam int AW = $clog2(DEPTH);
	localparam int PW = spq_pkg::CNT_W + 1;
	localparam logic [spq_pkg::CNT_W-1:0] DEPTH_CNT = spq_pkg::CNT_W'(DEPTH);

	// map a position in sorted order to a RAM address
	function automatic logic [AW-1:0] phys(input logic [AW-1:0] head,
			input logic [spq_pkg::CNT_W-1:0] pos);
		logic [PW-1:0] sum;
		begin
			sum = PW'(head) + PW'(pos);
			if (sum >= PW'(DEPTH)) begin
				sum = sum - PW'(DEPTH);
			end
			phys = sum[AW-1:0];
		end
	endfunction

	spq_pkg::state_t state_q, state_nx;

	// configuration
	logic                              lbp_q;
	logic [spq_pkg::CNT_W-1:0]         max_packets_q;
	logic [spq_pkg::BYTES_W-1:0]       max_bytes_q;

	// queue status
	logic [AW-1:0]                     head_q, head_nx;
	logic [spq_pkg::CNT_W-1:0]         cnt_q, cnt_nx;
	logic [spq_pkg::BYTES_W-1:0]       byt_q, byt_nx;
	logic [spq_pkg::CNT_W-1:0]         pos_q, pos_nx;
	logic                              pushed_q, pushed_nx;
	spq_pkg::entry_t                   arr_q;

	// RAM port
	logic                              ram_we, ram_re;
	logic [AW-1:0]                     ram_waddr, ram_raddr;
	spq_pkg::entry_t                   ram_wdata, rd;

	// result emission
	logic                              emit;
	logic [spq_pkg::KIND_W-1:0]        emit_kind;
	spq_pkg::entry_t                   emit_entry;
	logic                              emit_last;

	// output register
	logic                              m_tvalid_q;
	logic [spq_pkg::KIND_W-1:0]        out_kind_q;
	spq_pkg::entry_t                   out_entry_q;
	logic [spq_pkg::CNT_W-1:0]         out_cnt_q;
	logic [spq_pkg::BYTES_W-1:0]       out_byt_q;
	logic                              out_last_q;

	logic                              s_fire, slot_free;
	logic [spq_pkg::CNT_W-1:0]         pkt_lim;
	logic [spq_pkg::BYTES_W:0]         byte_sum;
	logic                              over, can_push, rd_gt;

	spq_ram #(
		.W     ($bits(spq_pkg::entry_t)),
		.DEPTH (DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (rd)
	);

	assign s_tready  = (state_q == spq_pkg::ST_IDLE);
	assign s_fire    = s_tvalid && s_tready;
	// a result may be loaded when the output register is empty or drains this cycle
	assign slot_free = !m_tvalid_q || m_tready;

	// limit check of the current mode against the latched arrival
	assign pkt_lim  = (max_packets_q > DEPTH_CNT) ? DEPTH_CNT : max_packets_q;
	assign byte_sum = {1'b0, byt_q} + (spq_pkg::BYTES_W + 1)'(arr_q.bytes);
	assign over     = lbp_q ? (cnt_q >= pkt_lim)
	                        : ((byte_sum >= {1'b0, max_bytes_q}) || (cnt_q >= DEPTH_CNT));
	// packet mode pushes out at most one packet per arrival
	assign can_push = over && (cnt_q != '0) && !(lbp_q && pushed_q);
	// last word read (tail or scan position) ranks behind the arrival
	assign rd_gt    = rd.prio > arr_q.prio;

	// next state
	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			spq_pkg::ST_IDLE: begin
				if (s_fire) begin
					if (s_tuser == spq_pkg::CMD_DEQ) begin
						state_nx = (cnt_q == '0) ? spq_pkg::ST_EMPTY : spq_pkg::ST_DEQ;
					end else begin
						state_nx = spq_pkg::ST_CHECK;
					end
				end
			end
			spq_pkg::ST_CHECK: begin
				if (can_push) begin
					state_nx = spq_pkg::ST_TAIL;
				end else if (over) begin
					state_nx = spq_pkg::ST_DROP;
				end else if (cnt_q == '0) begin
					state_nx = spq_pkg::ST_PLACE;
				end else begin
					state_nx = spq_pkg::ST_SCAN;
				end
			end
			spq_pkg::ST_TAIL: begin
				if (!rd_gt) begin
					state_nx = spq_pkg::ST_DROP;
				end else if (slot_free) begin
					state_nx = spq_pkg::ST_CHECK;
				end
			end
			spq_pkg::ST_SCAN: begin
				if (!rd_gt || pos_q == spq_pkg::CNT_W'(1)) begin
					state_nx = spq_pkg::ST_PLACE;
				end
			end
			spq_pkg::ST_DROP, spq_pkg::ST_PLACE, spq_pkg::ST_DEQ, spq_pkg::ST_EMPTY: begin
				if (slot_free) begin
					state_nx = spq_pkg::ST_IDLE;
				end
			end
			default: begin
				state_nx = spq_pkg::ST_IDLE;
			end
		endcase
	end

	// datapath control and status updates
	always_comb begin
		ram_re     = 1'b0;
		ram_raddr  = head_q;
		ram_we     = 1'b0;
		ram_waddr  = phys(head_q, pos_q);
		ram_wdata  = rd;
		emit       = 1'b0;
		emit_kind  = spq_pkg::KIND_ACCEPTED;
		emit_entry = arr_q;
		emit_last  = 1'b1;
		head_nx    = head_q;
		cnt_nx     = cnt_q;
		byt_nx     = byt_q;
		pos_nx     = pos_q;
		pushed_nx  = pushed_q;
		unique case (state_q)
			spq_pkg::ST_IDLE: begin
				pushed_nx = 1'b0;
				// fetch the head early for a dequeue
				if (s_fire && s_tuser == spq_pkg::CMD_DEQ && cnt_q != '0) begin
					ram_re = 1'b1;
				end
			end
			spq_pkg::ST_CHECK: begin
				pos_nx    = cnt_q;
				ram_raddr = phys(head_q, cnt_q - spq_pkg::CNT_W'(1));
				if (can_push || (!over && cnt_q != '0)) begin
					ram_re = 1'b1;
				end
			end
			spq_pkg::ST_TAIL: begin
				if (rd_gt && slot_free) begin
					emit       = 1'b1;
					emit_kind  = spq_pkg::KIND_PUSHED;
					emit_entry = rd;
					emit_last  = 1'b0;
					cnt_nx     = cnt_q - spq_pkg::CNT_W'(1);
					byt_nx     = byt_q - spq_pkg::BYTES_W'(rd.bytes);
					pushed_nx  = 1'b1;
				end
			end
			spq_pkg::ST_SCAN: begin
				// shift one entry up per cycle, reading the next one down ahead
				ram_raddr = phys(head_q, pos_q - spq_pkg::CNT_W'(2));
				if (rd_gt) begin
					ram_we = 1'b1;
					pos_nx = pos_q - spq_pkg::CNT_W'(1);
					if (pos_q != spq_pkg::CNT_W'(1)) begin
						ram_re = 1'b1;
					end
				end
			end
			spq_pkg::ST_PLACE: begin
				ram_wdata = arr_q;
				if (slot_free) begin
					ram_we = 1'b1;
					emit   = 1'b1;
					cnt_nx = cnt_q + spq_pkg::CNT_W'(1);
					byt_nx = byt_q + spq_pkg::BYTES_W'(arr_q.bytes);
				end
			end
			spq_pkg::ST_DROP: begin
				if (slot_free) begin
					emit      = 1'b1;
					emit_kind = spq_pkg::KIND_DROPPED;
				end
			end
			spq_pkg::ST_DEQ: begin
				if (slot_free) begin
					emit       = 1'b1;
					emit_kind  = spq_pkg::KIND_DEQUEUED;
					emit_entry = rd;
					head_nx    = phys(head_q, spq_pkg::CNT_W'(1));
					cnt_nx     = cnt_q - spq_pkg::CNT_W'(1);
					byt_nx     = byt_q - spq_pkg::BYTES_W'(rd.bytes);
				end
			end
			spq_pkg::ST_EMPTY: begin
				if (slot_free) begin
					emit       = 1'b1;
					emit_kind  = spq_pkg::KIND_DEQ_EMPTY;
					emit_entry = '0;
				end
			end
			default: begin
				emit = 1'b0;
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= spq_pkg::ST_IDLE;
			lbp_q         <= 1'b0;
			max_packets_q <= spq_pkg::MAX_PACKETS_RST;
			max_bytes_q   <= spq_pkg::MAX_BYTES_RST;
			head_q        <= '0;
			cnt_q         <= '0;
			byt_q         <= '0;
			pos_q         <= '0;
			pushed_q      <= 1'b0;
			m_tvalid_q    <= 1'b0;
		end else begin
			state_q  <= state_nx;
			head_q   <= head_nx;
			cnt_q    <= cnt_nx;
			byt_q    <= byt_nx;
			pos_q    <= pos_nx;
			pushed_q <= pushed_nx;
			if (emit) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			if (cfg_we) begin
				unique case (cfg_index)
					spq_pkg::CFG_LIMIT_BY_PACKETS: lbp_q <= cfg_data[0];
					spq_pkg::CFG_MAX_PACKETS:      max_packets_q <= cfg_data[spq_pkg::CNT_W-1:0];
					spq_pkg::CFG_MAX_BYTES:        max_bytes_q <= cfg_data[spq_pkg::BYTES_W-1:0];
					default: begin
						// unknown index: drop the write
						lbp_q <= lbp_q;
					end
				endcase
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (s_fire) begin
			arr_q.handle <= s_tdata[15:0];
			arr_q.prio   <= s_tdata[47:16];
			arr_q.bytes  <= s_tdata[63:48];
		end
		if (emit) begin
			out_kind_q  <= emit_kind;
			out_entry_q <= emit_entry;
			out_cnt_q   <= cnt_nx;
			out_byt_q   <= byt_nx;
			out_last_q  <= emit_last;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tuser  = out_kind_q;
	assign m_tlast  = out_last_q;
	assign m_tdata  = {2'b00, out_byt_q, out_cnt_q, out_entry_q.bytes, out_entry_q.prio,
	                   out_entry_q.handle};

endmodule
`default_nettype wire

// ===== rtl/core/spq_ram.sv =====
// Generic simple dual-port RAM with one write port and a registered read port.
`default_nettype none
module spq_ram #(
	parameter int W     = 64,
	parameter int DEPTH = 32
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [W-1:0]             wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [W-1:0]             rdata
);

	logic [W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		// hold the last read word while re is low
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
`default_nettype wire

// ===== rtl/core/spq_checker.sv =====
// Port-level checks of the sorted priority queue, bound to the top level.
`default_nettype none
module spq_checker #(
	parameter int DEPTH = 32
) (
	input wire logic                           clk,
	input wire logic                           arst_n,
	input wire logic                           s_tvalid,
	input wire logic                           s_tready,
	input wire logic                           m_tvalid,
	input wire logic                           m_tready,
	input wire logic [spq_pkg::M_DATA_W-1:0]   m_tdata,
	input wire logic [spq_pkg::KIND_W-1:0]     m_tuser,
	input wire logic                           m_tlast
);

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
			&& $stable(m_tlast))
		else $error("result changed while stalled");

	// one input beat at a time
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input taken while a beat is in work");

	// only push-out results are followed by more results of the same beat
	a_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tlast == (m_tuser != spq_pkg::KIND_PUSHED)))
		else $error("tlast does not match result kind");

	// dequeue on empty reports an empty queue and zero packet fields
	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == spq_pkg::KIND_DEQ_EMPTY |->
			m_tdata[69:0] == 70'd0 && m_tdata[93:70] == 24'd0)
		else $error("empty dequeue result not clean");

	// count and kind stay in range
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[69:64] <= spq_pkg::CNT_W'(DEPTH)
			&& m_tuser <= spq_pkg::KIND_DEQ_EMPTY)
		else $error("result field out of range");

endmodule

bind pushout_sorted_priority_queue spq_checker #(.DEPTH(DEPTH)) u_spq_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser),
	.m_tlast  (m_tlast)
);
`default_nettype wire
